>>> rtl/core/per_pixel_running_mean_accumulator_defines.svh
// Assertion macros for the checks in the top-level module.
`ifndef PER_PIXEL_RUNNING_MEAN_ACCUMULATOR_DEFINES_SVH
`define PER_PIXEL_RUNNING_MEAN_ACCUMULATOR_DEFINES_SVH

// Condition a in a cycle implies condition b in the same cycle.
`define PPRA_ASSERT_SAME(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// Condition a in a cycle implies condition b in the next cycle.
`define PPRA_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/core/ppra_pkg.sv
`default_nettype none
package ppra_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int MAX_BANDS   = 256;
	localparam int TABLE_DEPTH = MAX_SAMPLES * MAX_BANDS;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int DIV_W       = 32;
	localparam int ENTRY_W     = 2 * DIV_W;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [1:0] OP_ACC   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] CFG_NUM_SAMPLES  = 3'd0;
	localparam logic [2:0] CFG_NUM_BANDS    = 3'd1;
	localparam logic [2:0] CFG_START_LINE   = 3'd2;
	localparam logic [2:0] CFG_END_LINE     = 3'd3;
	localparam logic [2:0] CFG_START_SAMPLE = 3'd4;
	localparam logic [2:0] CFG_END_SAMPLE   = 3'd5;
	localparam logic [2:0] CFG_PER_BAND     = 3'd6;

	typedef enum logic [1:0] {
		CMD_ACC,
		CMD_READ,
		CMD_ZERO,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [15:0]       value;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
		logic accumulating;
		logic div_busy;
	} bk_sts_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RDATA,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage
`default_nettype wire

>>> rtl/core/ppra_ram.sv
`default_nettype none
module ppra_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ppra_fifo.sv
`default_nettype none
module ppra_fifo import ppra_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output      logic ready,
	output      logic valid,
	output      cmd_t data,
	input  wire logic pop
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready = count_q != CNT_W'(FIFO_DEPTH);
	assign valid = count_q != '0;
	assign data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ppra_front.sv
`default_nettype none
module ppra_front import ppra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] line_index,
	input  wire logic [7:0]  band_index,
	input  wire logic [9:0]  sample_index,
	input  wire logic [15:0] pixel_value,
	input  wire logic        init_busy,
	input  wire logic        q_ready,
	output      logic        q_push,
	output      cmd_t        q_cmd
);

	logic [10:0] num_samples_q;
	logic [8:0]  num_bands_q;
	logic [15:0] start_line_q;
	logic [15:0] end_line_q;
	logic [9:0]  start_sample_q;
	logic [9:0]  end_sample_q;
	logic        per_band_q;

	logic [10:0] eff_s;
	logic [8:0]  eff_b;
	logic [9:0]  eff_end;
	logic [9:0]  smp_lo;
	logic [9:0]  rd_smp;
	logic [9:0]  sel_smp;
	logic [18:0] flat;
	logic [IDX_W-1:0] idx;
	logic        in_win;
	logic        want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q  <= 11'd1024;
			num_bands_q    <= 9'd256;
			start_line_q   <= 16'd0;
			end_line_q     <= 16'hFFFF;
			start_sample_q <= 10'd0;
			end_sample_q   <= 10'd1023;
			per_band_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_SAMPLES:  num_samples_q  <= cfg_data[10:0];
				CFG_NUM_BANDS:    num_bands_q    <= cfg_data[8:0];
				CFG_START_LINE:   start_line_q   <= cfg_data;
				CFG_END_LINE:     end_line_q     <= cfg_data;
				CFG_START_SAMPLE: start_sample_q <= cfg_data[9:0];
				CFG_END_SAMPLE:   end_sample_q   <= cfg_data[9:0];
				CFG_PER_BAND:     per_band_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective geometry with the registers clamped to the table limits.
	always_comb begin
		eff_s = (num_samples_q == '0) ? 11'd1 :
			(num_samples_q > 11'(MAX_SAMPLES)) ? 11'(MAX_SAMPLES) : num_samples_q;
		eff_b = (num_bands_q == '0) ? 9'd1 :
			(num_bands_q > 9'(MAX_BANDS)) ? 9'(MAX_BANDS) : num_bands_q;
		eff_end = ({1'b0, end_sample_q} > (eff_s - 11'd1)) ? 10'(eff_s - 11'd1) : end_sample_q;
		smp_lo  = (sample_index < start_sample_q) ? start_sample_q : sample_index;
		rd_smp  = (smp_lo > eff_end) ? eff_end : smp_lo;
		sel_smp = (opcode == OP_READ) ? rd_smp : sample_index;
		flat    = 19'(band_index) * 19'(eff_s) + 19'(sel_smp);
		idx     = per_band_q ? IDX_W'(band_index) : flat[IDX_W-1:0];
		in_win  = ({1'b0, band_index} < eff_b)
			&& (line_index >= start_line_q) && (line_index <= end_line_q)
			&& (sample_index >= start_sample_q) && (sample_index <= eff_end);
	end

	always_comb begin
		q_cmd.idx   = idx;
		q_cmd.value = pixel_value;
		q_cmd.kind  = CMD_ACC;
		want        = 1'b0;
		unique case (opcode)
			OP_ACC: begin
				want = in_win;
			end
			OP_READ: begin
				want       = 1'b1;
				q_cmd.kind = ({1'b0, band_index} < eff_b) ? CMD_READ : CMD_ZERO;
			end
			OP_CLEAR: begin
				want       = 1'b1;
				q_cmd.kind = CMD_CLEAR;
			end
			default: ;
		endcase
	end

	assign in_ready = !init_busy && q_ready;
	assign q_push   = in_valid && in_ready && want;

endmodule
`default_nettype wire

>>> rtl/core/ppra_div.sv
`default_nettype none
module ppra_div import ppra_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output      logic             busy,
	output      logic             done,
	output      logic [DIV_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIV_W);

	logic [DIV_W:0]    rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    rem_sh;
	logic              fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/ppra_back.sv
`default_nettype none
module ppra_back import ppra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire cmd_t        q_cmd,
	output      logic        q_pop,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] mean_value,
	output      logic [31:0] sample_count,
	output      bk_sts_t     sts
);

	bk_state_t        state_q, state_d;
	cmd_t             cmd_q;
	logic [31:0]      cnt_q;
	logic [31:0]      mean_q;
	logic             up_q;
	logic [31:0]      res_mean_q;
	logic [31:0]      res_cnt_q;
	logic [IDX_W-1:0] clr_ptr_q;
	logic             init_q;
	logic             out_valid_q;
	logic [31:0]      out_mean_q;
	logic [31:0]      out_cnt_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               load_out;
	logic               clr_last;

	logic [31:0] rd_mean;
	logic [31:0] rd_cnt;
	logic [31:0] cnt_new;
	logic [31:0] target;
	logic        up;
	logic [31:0] diff;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [31:0] quo;
	logic [31:0] mean_new;

	ppra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (q_cmd.idx),
		.rdata (ram_rdata)
	);

	ppra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (cnt_new),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// Entry update: bump the count (saturating), then move the mean toward the pixel.
	always_comb begin
		rd_mean  = ram_rdata[ENTRY_W-1:DIV_W];
		rd_cnt   = ram_rdata[DIV_W-1:0];
		cnt_new  = (rd_cnt == '1) ? rd_cnt : rd_cnt + 32'd1;
		target   = {cmd_q.value, 16'd0};
		up       = target >= rd_mean;
		diff     = up ? target - rd_mean : rd_mean - target;
		mean_new = up_q ? mean_q + quo : mean_q - quo;
		clr_last = clr_ptr_q == IDX_W'(TABLE_DEPTH - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cmd_q.idx;
		ram_wdata = {mean_new, cnt_q};
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_ptr_q;
				ram_wdata = '0;
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.kind)
						CMD_CLEAR: state_d = BK_CLEAR;
						CMD_ZERO:  state_d = BK_OUT;
						CMD_ACC, CMD_READ: begin
							ram_re  = 1'b1;
							state_d = BK_RDATA;
						end
					endcase
				end
			end
			BK_RDATA: begin
				if (cmd_q.kind == CMD_READ) begin
					state_d = BK_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					ram_we  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q      <= q_cmd;
			res_mean_q <= '0;
			res_cnt_q  <= '0;
		end
		if (state_q == BK_RDATA) begin
			cnt_q      <= cnt_new;
			mean_q     <= rd_mean;
			up_q       <= up;
			res_mean_q <= rd_mean;
			res_cnt_q  <= rd_cnt;
		end
		if (load_out) begin
			out_mean_q <= res_mean_q;
			out_cnt_q  <= res_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q   <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_ptr_q <= clr_last ? '0 : clr_ptr_q + 1'b1;
				if (clr_last) begin
					init_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign mean_value       = out_mean_q;
	assign sample_count     = out_cnt_q;
	assign sts.init_busy    = init_q;
	assign sts.accumulating = (state_q == BK_RDATA) || (state_q == BK_DIV);
	assign sts.div_busy     = div_busy;

endmodule
`default_nettype wire

>>> rtl/core/per_pixel_running_mean_accumulator.sv
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// input    | in_valid/in_ready, opcode, line/band/sample,   | in
//          | pixel_value                                    |
// result   | out_valid/out_ready, mean_value, sample_count  | out
// config   | cfg_we, cfg_index, cfg_data                    | in
//
// An accumulate word goes through one table read in the back end, a 32-step radix-2
// divider for the mean correction, and one write-back. A read word takes a table read
// and waits for a free output register; a clear sweeps the table, one entry a cycle.
// After reset the table's 262144 entries are swept to zero, and in_ready stays low.
// A two-entry queue separates the front classifier from the back end, so input
// words are taken while a result waits on a stalled output.
`default_nettype none
`include "per_pixel_running_mean_accumulator_defines.svh"
module per_pixel_running_mean_accumulator import ppra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] line_index,
	input  wire logic [7:0]  band_index,
	input  wire logic [9:0]  sample_index,
	input  wire logic [15:0] pixel_value,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] mean_value,
	output      logic [31:0] sample_count
);

	// Classified commands travel through the queue to the back end.
	logic    q_push;
	cmd_t    push_cmd;
	logic    q_ready;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    q_pop;
	bk_sts_t sts;

	ppra_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.line_index   (line_index),
		.band_index   (band_index),
		.sample_index (sample_index),
		.pixel_value  (pixel_value),
		.init_busy    (sts.init_busy),
		.q_ready      (q_ready),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	ppra_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.ready     (q_ready),
		.valid     (q_valid),
		.data      (q_cmd),
		.pop       (q_pop)
	);

	ppra_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_value   (mean_value),
		.sample_count (sample_count),
		.sts          (sts)
	);

	// The startup sweep must hold off input words and produce no results.
	`PPRA_ASSERT_SAME(a_init_blocks_input, sts.init_busy, !in_ready, "input taken during sweep")
	`PPRA_ASSERT_SAME(a_init_no_result, sts.init_busy, !out_valid, "result during sweep")
	// The divider only runs for an accumulate in progress.
	`PPRA_ASSERT_SAME(a_div_in_acc, sts.div_busy, sts.accumulating, "divider busy outside update")
	// The back end only pops a command it was offered.
	`PPRA_ASSERT_SAME(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
	import ppra_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The package gives no name to the unused opcode, so the bench names it here.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [2:0]  cfg_index    = CFG_NUM_SAMPLES;
	logic [15:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode       = OP_ACC;
	logic [15:0] line_index   = '0;
	logic [7:0]  band_index   = '0;
	logic [9:0]  sample_index = '0;
	logic [15:0] pixel_value  = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [31:0] mean_value;
	logic [31:0] sample_count;

	per_pixel_running_mean_accumulator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .line_index(line_index), .band_index(band_index),
		.sample_index(sample_index), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_value(mean_value), .sample_count(sample_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the configuration registers, at their register widths.
	logic [10:0] sh_num_samples;
	logic [8:0]  sh_num_bands;
	logic [15:0] sh_start_line;
	logic [15:0] sh_end_line;
	logic [9:0]  sh_start_sample;
	logic [9:0]  sh_end_sample;
	logic        sh_per_band;

	// Sparse shadow of the table's mean and count fields; an entry that is absent reads as zero.
	logic [31:0] mean_tab[int unsigned];
	logic [31:0] count_tab[int unsigned];

	typedef struct {
		logic [31:0] mean;
		logic [31:0] count;
	} entry_read_t;

	entry_read_t pending_reads[$];

	int fail_cnt   = 0;
	int words_sent = 0;
	int reads_seen = 0;
	int acc_taken  = 0;

	bit tx_gaps   = 1'b0;
	bit rx_stalls = 1'b0;
	int rx_hold   = 0;
	int rx_burst  = 0;

	function automatic int unsigned eff_samples();
		if (sh_num_samples == 0) return 1;
		if (sh_num_samples > MAX_SAMPLES) return MAX_SAMPLES;
		return sh_num_samples;
	endfunction

	function automatic int unsigned eff_bands();
		if (sh_num_bands == 0) return 1;
		if (sh_num_bands > MAX_BANDS) return MAX_BANDS;
		return sh_num_bands;
	endfunction

	function automatic int unsigned eff_last_sample();
		int unsigned last;
		last = eff_samples() - 1;
		return (sh_end_sample > last) ? last : sh_end_sample;
	endfunction

	function automatic int unsigned table_slot(int unsigned band, int unsigned sample);
		int unsigned idx;
		idx = sh_per_band ? band : band * eff_samples() + sample;
		return (idx < TABLE_DEPTH) ? idx : 0;
	endfunction

	// Folds one pixel into an entry: bump the saturating count, then move the mean
	// toward the pixel by the truncated quotient of the distance over the count.
	function automatic void fold_pixel(int unsigned idx, logic [15:0] value);
		logic [31:0] cnt;
		logic [31:0] mean;
		logic [31:0] target;
		cnt    = count_tab.exists(idx) ? count_tab[idx] : 32'd0;
		mean   = mean_tab.exists(idx) ? mean_tab[idx] : 32'd0;
		target = {value, 16'h0000};
		if (cnt != 32'hFFFF_FFFF) cnt = cnt + 1;
		if (target >= mean) mean = mean + (target - mean) / cnt;
		else mean = mean - (mean - target) / cnt;
		count_tab[idx] = cnt;
		mean_tab[idx]  = mean;
	endfunction

	// Works out what an accepted word does to the shadow tables and what it returns.
	function automatic void predict_word(logic [1:0] op, logic [15:0] line, logic [7:0] band,
			logic [9:0] sample, logic [15:0] value);
		int unsigned es;
		int unsigned smp;
		int unsigned idx;
		entry_read_t rd;
		es = eff_last_sample();
		case (op)
			OP_ACC: begin
				if (band < eff_bands() && line >= sh_start_line && line <= sh_end_line &&
						sample >= sh_start_sample && sample <= es) begin
					fold_pixel(table_slot(band, sample), value);
					acc_taken++;
				end
			end
			OP_READ: begin
				rd.mean  = '0;
				rd.count = '0;
				if (band < eff_bands()) begin
					// Out-of-window reads are pulled to the nearest edge, low edge first.
					smp = sample;
					if (smp < sh_start_sample) smp = sh_start_sample;
					if (smp > es) smp = es;
					idx = table_slot(band, smp);
					if (mean_tab.exists(idx)) rd.mean = mean_tab[idx];
					if (count_tab.exists(idx)) rd.count = count_tab[idx];
				end
				pending_reads.insert(pending_reads.size(), rd);
			end
			OP_CLEAR: begin
				mean_tab.delete();
				count_tab.delete();
			end
			default: begin
			end
		endcase
	endfunction

	// Offers one word, with an optional random gap in front of it, and holds it
	// until the block takes it. Returns at the edge of acceptance.
	task automatic send_word(logic [1:0] op, logic [15:0] line, logic [7:0] band,
			logic [9:0] sample, logic [15:0] value);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		line_index   <= line;
		band_index   <= band;
		sample_index <= sample;
		pixel_value  <= value;
		do @(posedge clk); while (!in_ready);
		predict_word(op, line, band, sample, value);
		words_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every read has come back, then lets the accumulates that may
	// still sit in the queue and the divider finish before anything touches the
	// registers.
	task automatic drain_results();
		go_idle();
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Writes all seven registers on consecutive edges; the enable only drops after
	// the last one so it never gets two updates in one step.
	task automatic load_config(logic [10:0] ns, logic [8:0] nb, logic [15:0] sl,
			logic [15:0] el, logic [9:0] ss, logic [9:0] es, logic pb);
		logic [15:0] vals[7];
		vals = '{16'(ns), 16'(nb), sl, el, 16'(ss), 16'(es), 16'(pb)};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		sh_num_samples  = ns;
		sh_num_bands    = nb;
		sh_start_line   = sl;
		sh_end_line     = el;
		sh_start_sample = ss;
		sh_end_sample   = es;
		sh_per_band     = pb;
	endtask

	// Receiver: a long hold requested by a test wins, otherwise random stall bursts.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_burst > 0) begin
			out_ready <= 1'b0;
			rx_burst = rx_burst - 1;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rx_burst = $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker: every accepted result word is matched against the oldest read.
	always @(posedge clk) begin
		entry_read_t exp_rd;
		if (arst_n && out_valid && out_ready) begin
			reads_seen++;
			if (pending_reads.size() == 0) begin
				$error("result word with no read outstanding: mean %h count %h",
					mean_value, sample_count);
				fail_cnt++;
			end else begin
				exp_rd = pending_reads.pop_front();
				if (mean_value !== exp_rd.mean) begin
					$error("mean_value expected %h actual %h", exp_rd.mean, mean_value);
					fail_cnt++;
				end
				if (sample_count !== exp_rd.count) begin
					$error("sample_count expected %h actual %h", exp_rd.count, sample_count);
					fail_cnt++;
				end
			end
		end
	end

	// Reset defaults: extreme pixel values and corners of the full-size table.
	task automatic test_reset_defaults();
		send_word(OP_READ, 16'h0000, 8'd0, 10'd0, 16'h0000);
		send_word(OP_ACC, 16'h0000, 8'd0, 10'd0, 16'hFFFF);
		send_word(OP_ACC, 16'hFFFF, 8'd0, 10'd0, 16'h0000);
		send_word(OP_ACC, 16'hFFFF, 8'd255, 10'd1023, 16'hFFFF);
		send_word(OP_UNUSED, 16'hFFFF, 8'd255, 10'd1023, 16'hFFFF);
		send_word(OP_READ, 16'h0000, 8'd0, 10'd0, 16'h0000);
		send_word(OP_READ, 16'h0000, 8'd255, 10'd1023, 16'h0000);
		drain_results();
	endtask

	// A small window: pixels outside the lines, samples or bands are dropped, and
	// reads outside the sample window land on its nearest edge.
	task automatic test_window_edges();
		load_config(11'd4, 9'd3, 16'd10, 16'd20, 10'd1, 10'd2, 1'b0);
		send_word(OP_ACC, 16'd10, 8'd2, 10'd1, 16'd1000);
		send_word(OP_ACC, 16'd9, 8'd2, 10'd1, 16'd5);
		send_word(OP_ACC, 16'd21, 8'd2, 10'd2, 16'd5);
		send_word(OP_ACC, 16'd20, 8'd2, 10'd2, 16'd3);
		send_word(OP_ACC, 16'd15, 8'd3, 10'd1, 16'd7);
		send_word(OP_ACC, 16'd15, 8'd1, 10'd3, 16'd7);
		send_word(OP_READ, 16'd0, 8'd2, 10'd0, 16'd0);
		send_word(OP_READ, 16'd0, 8'd2, 10'd1023, 16'd0);
		send_word(OP_READ, 16'd0, 8'd200, 10'd1, 16'd0);
		drain_results();
	endtask

	// Out-of-range register values, empty windows and per-band mode, then a clear.
	task automatic test_register_extremes();
		load_config(11'd0, 9'd0, 16'hFFFF, 16'hFFFF, 10'd0, 10'd1023, 1'b1);
		send_word(OP_ACC, 16'hFFFF, 8'd0, 10'd0, 16'hABCD);
		send_word(OP_READ, 16'd0, 8'd0, 10'd999, 16'd0);
		drain_results();
		// Empty sample window: the read falls on the clamped last sample.
		load_config(11'd2047, 9'd511, 16'd5, 16'd4, 10'd1023, 10'd3, 1'b0);
		send_word(OP_ACC, 16'd4, 8'd0, 10'd3, 16'd9);
		send_word(OP_READ, 16'd0, 8'd0, 10'd1023, 16'd0);
		drain_results();
		send_word(OP_CLEAR, 16'd0, 8'd0, 10'd0, 16'd0);
		send_word(OP_READ, 16'd0, 8'd255, 10'd1023, 16'd0);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while reads keep coming, so the
	// output and the internal queue fill up and the input stalls.
	task automatic test_backpressure();
		load_config(11'd8, 9'd4, 16'd0, 16'hFFFF, 10'd0, 10'd7, 1'b0);
		rx_hold = 600;
		for (int i = 0; i < 12; i++)
			send_word(OP_READ, 16'd0, 8'($urandom_range(0, 3)), 10'($urandom_range(0, 7)), 16'd0);
		drain_results();
	endtask

	task automatic random_config();
		logic [10:0] ns;
		logic [8:0]  nb;
		logic [15:0] sl;
		logic [9:0]  ss;
		case ($urandom_range(0, 5))
			0: ns = 11'($urandom_range(1025, 2047));
			1: ns = 11'd0;
			2: ns = 11'd1024;
			default: ns = 11'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 4))
			0: nb = 9'($urandom_range(257, 511));
			1: nb = 9'd0;
			default: nb = 9'($urandom_range(1, 6));
		endcase
		sl = 16'($urandom_range(0, 65535));
		ss = 10'($urandom_range(0, 4));
		load_config(ns, nb, sl, 16'(sl + $urandom_range(0, 40)), ss,
			10'(ss + $urandom_range(0, 8)), 1'($urandom_range(0, 1)));
	endtask

	// Mostly pixels that land in a small window so counts climb, with reads mixed
	// in; a tenth of the words are unrestricted noise.
	task automatic random_word();
		logic [1:0]  op;
		logic [15:0] line;
		int          band;
		int          smp;
		if ($urandom_range(0, 9) == 0) begin
			op = $urandom_range(0, 2) == 2 ? OP_UNUSED : 2'($urandom_range(0, 1));
			send_word(op, 16'($urandom), 8'($urandom), 10'($urandom), 16'($urandom));
		end else begin
			op   = $urandom_range(0, 4) == 0 ? OP_READ : OP_ACC;
			line = 16'(sh_start_line + $urandom_range(0, 40));
			band = $urandom_range(0, eff_bands() < 8 ? eff_bands() : 8);
			smp  = int'(sh_start_sample) + $urandom_range(0, 10) - 1;
			if (smp < 0) smp = 0;
			send_word(op, line, 8'(band), 10'(smp), 16'($urandom));
		end
	endtask

	task automatic test_random_traffic(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			random_config();
			for (int i = 0; i < per_phase; i++) random_word();
			drain_results();
		end
	endtask

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		sh_num_samples  = 11'd1024;
		sh_num_bands    = 9'd256;
		sh_start_line   = 16'd0;
		sh_end_line     = 16'hFFFF;
		sh_start_sample = 10'd0;
		sh_end_sample   = 10'd1023;
		sh_per_band     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_window_edges();
		test_register_extremes();
		test_backpressure();
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		test_random_traffic(5, 220);
		// Closing stretch runs at full rate on both sides.
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		test_random_traffic(1, 240);

		go_idle();
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d words; %0d pixels folded into the means, %0d reads checked.",
			words_sent, acc_taken, reads_seen);
		$display("Covered window clamps, out-of-range registers, both modes, clear and stalls.");
		if (fail_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> per_pixel_running_mean_accumulator.f
+incdir+rtl/core
rtl/core/ppra_pkg.sv
rtl/core/ppra_ram.sv
rtl/core/ppra_fifo.sv
rtl/core/ppra_front.sv
rtl/core/ppra_div.sv
rtl/core/ppra_back.sv
rtl/core/per_pixel_running_mean_accumulator.sv
test/tb_top.sv
